// ===== rtl/knp_pkg.sv =====
// Shared types and constants of the k nearest points search.
// Used by knp_cand_cell, knp_cand_chain and k_nearest_points_3d; depends on nothing.
package knp_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int MAX_NEIGHBORS_DEF = 16;
  localparam int COORD_BITS_DEF    = 24;

  localparam int CAND_EXTRA = 6;

  localparam int ACTION_W   = 2;
  localparam int AXIS_W     = 2;
  localparam int RANK_W     = 10;
  localparam int PIDX_W     = 10;
  localparam int NIDX_W     = 10;
  localparam int NPOS_W     = 4;
  localparam int OUT_DATA_W = 16;

  localparam int PCOUNT_W    = 11;
  localparam int NCOUNT_W    = 5;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;

  localparam logic [ACTION_W-1:0] ACT_LOAD_POINT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_ORDER = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY      = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOR_COUNT = 1'b1;

  typedef struct packed {
    logic clear;
    logic insert;
    logic trunc;
  } chain_cmd_t;

endpackage

// ===== rtl/knp_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module knp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/knp_cand_cell.sv =====
// One candidate slot of the sorted candidate row: distance, point, valid.
// Depends on knp_pkg for the row command.
module knp_cand_cell #(
  parameter int DW = 50,
  parameter int IW = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  knp_pkg::chain_cmd_t cmd,
  input  logic                keep,
  input  logic [DW-1:0]       new_d,
  input  logic [IW-1:0]       new_p,
  input  logic                prev_lt,
  input  logic                prev_valid,
  input  logic [DW-1:0]       prev_d,
  input  logic [IW-1:0]       prev_p,
  output logic                lt,
  output logic                valid,
  output logic [DW-1:0]       d,
  output logic [IW-1:0]       p,
  output logic                hit
);

  logic          valid_r, valid_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [IW-1:0] p_r, p_nxt;

  assign lt    = !valid_r || (new_d < d_r) || ((new_d == d_r) && (new_p < p_r));
  assign hit   = valid_r && (p_r == new_p);
  assign valid = valid_r;
  assign d     = d_r;
  assign p     = p_r;

  always_comb begin
    valid_nxt = valid_r;
    d_nxt     = d_r;
    p_nxt     = p_r;
    priority if (cmd.clear) begin
      valid_nxt = 1'b0;
    end else if (cmd.insert) begin
      priority if (prev_lt) begin
        valid_nxt = prev_valid;
        d_nxt     = prev_d;
        p_nxt     = prev_p;
      end else if (lt) begin
        valid_nxt = 1'b1;
        d_nxt     = new_d;
        p_nxt     = new_p;
      end
    end else if (cmd.trunc) begin
      valid_nxt = valid_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    p_r <= p_nxt;
  end

endmodule

// ===== rtl/knp_cand_chain.sv =====
// Row of candidate cells kept sorted by (distance, point); shifts on insert.
// Depends on knp_pkg and knp_cand_cell.
module knp_cand_chain #(
  parameter int DW   = 50,
  parameter int IW   = 10,
  parameter int KW   = 5,
  parameter int CAND = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  knp_pkg::chain_cmd_t cmd,
  input  logic [DW-1:0]       new_d,
  input  logic [IW-1:0]       new_p,
  input  logic [KW-1:0]       kk,
  input  logic [KW-1:0]       sel,
  output logic                hit_any,
  output logic [DW-1:0]       thr,
  output logic [DW-1:0]       rd_d,
  output logic [IW-1:0]       rd_p
);

  localparam int CIW = $clog2(CAND);

  logic          lt_w    [CAND];
  logic          valid_w [CAND];
  logic [DW-1:0] d_w     [CAND];
  logic [IW-1:0] p_w     [CAND];
  logic [CAND-1:0] hit_w;
  logic [CIW-1:0]  thr_sel;

  for (genvar i = 0; i < CAND; i++) begin : g_cell
    logic          pl, pv;
    logic [DW-1:0] pd;
    logic [IW-1:0] pp;
    if (i == 0) begin : g_head
      assign pl = 1'b0;
      assign pv = 1'b0;
      assign pd = '0;
      assign pp = '0;
    end else begin : g_body
      assign pl = lt_w[i-1];
      assign pv = valid_w[i-1];
      assign pd = d_w[i-1];
      assign pp = p_w[i-1];
    end
    knp_cand_cell #(.DW(DW), .IW(IW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .keep       (i < int'(kk)),
      .new_d      (new_d),
      .new_p      (new_p),
      .prev_lt    (pl),
      .prev_valid (pv),
      .prev_d     (pd),
      .prev_p     (pp),
      .lt         (lt_w[i]),
      .valid      (valid_w[i]),
      .d          (d_w[i]),
      .p          (p_w[i]),
      .hit        (hit_w[i])
    );
  end

  assign hit_any = |hit_w;
  assign thr_sel = CIW'(kk - KW'(1));

  always_comb begin
    thr  = '0;
    rd_d = '0;
    rd_p = '0;
    for (int i = 0; i < CAND; i++) begin
      if (CIW'(i) == thr_sel) begin
        thr = d_w[i];
      end
      if (CIW'(i) == CIW'(sel)) begin
        rd_d = d_w[i];
        rd_p = p_w[i];
      end
    end
  end

endmodule

// ===== rtl/k_nearest_points_3d.sv =====
// k nearest points in 3D over per-axis sorted orders: point and order stores,
// search sequencer, candidate row. Depends on knp_pkg, knp_ram, knp_cand_chain.
//
// Usage: items enter on in_* (tvalid/tready). Load-point and load-order items
// give no result; one may follow in every cycle while no query is in progress.
// A query gives k = min(neighbor_count, MAX_NEIGHBORS, point_count,
// MAX_POINTS) items on out_*, nearest first, out_tlast on the final one;
// k = 0 gives none. A query runs a binary search of up to ceil(log2(n+1))
// steps on each of the three axes, each step reading the order RAM, then
// the point RAM, then comparing; then reads, squares, sums and inserts each
// seed point; then per ring latches the threshold, runs six probe slots
// (a taken probe reads the order RAM, then the point RAM, squares, sums and
// inserts if below the threshold and new), forms the bound and compares
// the candidates against it in order; and last delivers the k results.
// in_tready is high only while no query is in progress; a query ends when
// its last result is loaded into the output register.
// The output register holds its item while out_tready is low; the search
// waits on it during result delivery only.
// Reset (rst_n low, synchronous) empties the candidate row, the output
// register and the sequencer and sets both counts to 1. The point and
// order stores are not cleared: load them before querying.
module k_nearest_points_3d #(
  parameter int MAX_POINTS    = knp_pkg::MAX_POINTS_DEF,
  parameter int MAX_NEIGHBORS = knp_pkg::MAX_NEIGHBORS_DEF,
  parameter int COORD_BITS    = knp_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [knp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [knp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // action, axis, rank, point_index, coord_x, coord_y, coord_z, zero fill
  input  logic [((24 + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // neighbor_index, neighbor_position, zero fill
  output logic [knp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);

  localparam int C    = COORD_BITS;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 2);
  localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int CAND = MAX_NEIGHBORS + knp_pkg::CAND_EXTRA;
  localparam int SW   = 2 * C;
  localparam int DW   = 2 * C + 2;
  localparam int BW   = DW + 2;
  localparam int X_LO = 24;
  localparam int Y_LO = 24 + C;
  localparam int Z_LO = 24 + 2 * C;

  typedef enum logic [3:0] {
    S_IDLE, S_LOC_ORD, S_LOC_PT, S_LOC_CMP, S_SEED_RD, S_SQ, S_SUM, S_ACT,
    S_RING, S_PRB_SEL, S_PRB_PT, S_BOUND, S_CONF, S_EMIT
  } state_t;

  // input fields
  logic [knp_pkg::ACTION_W-1:0] f_action;
  logic [knp_pkg::AXIS_W-1:0]   f_axis;
  logic [knp_pkg::RANK_W-1:0]   f_rank;
  logic [knp_pkg::PIDX_W-1:0]   f_pidx;
  logic signed [C-1:0]          f_coord [3];

  assign f_action   = in_tdata[1:0];
  assign f_axis     = in_tdata[3:2];
  assign f_rank     = in_tdata[13:4];
  assign f_pidx     = in_tdata[23:14];
  assign f_coord[0] = in_tdata[X_LO +: C];
  assign f_coord[1] = in_tdata[Y_LO +: C];
  assign f_coord[2] = in_tdata[Z_LO +: C];

  state_t state_r, state_nxt;
  logic [knp_pkg::PCOUNT_W-1:0] pc_r;
  logic [knp_pkg::NCOUNT_W-1:0] nc_r;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [knp_pkg::NIDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [knp_pkg::NPOS_W-1:0]   out_pos_r, out_pos_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [1:0]          ax_r, ax_nxt;
  logic [NW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NW-1:0]       pos_r [3];
  logic [NW-1:0]       pos_nxt [3];
  logic signed [C-1:0] q_r [3];
  logic signed [C-1:0] q_nxt [3];
  logic [NW-1:0]       n_r, n_nxt;
  logic [KW-1:0]       kk_r, kk_nxt, cnt_r, cnt_nxt, cp_r, cp_nxt;
  logic [NW-1:0]       ring_r, ring_nxt;
  logic [2:0]          slot_r, slot_nxt;
  logic                seeding_r, seeding_nxt;
  logic [IW-1:0]       p_r, p_nxt;
  logic [SW-1:0]       sq_r [3];
  logic [SW-1:0]       sq_nxt [3];
  logic [DW-1:0]       d_r, d_nxt;
  logic [SW-1:0]       off_r, off_nxt;
  logic [DW-1:0]       offs_r [6];
  logic [DW-1:0]       offs_nxt [6];
  logic [DW-1:0]       thr_r, thr_nxt;
  logic [BW-1:0]       bound_r, bound_nxt;

  logic [NW-1:0] n_calc;
  logic [KW-1:0] kk_calc;
  logic          in_fire;

  // memories
  logic                st_we;
  logic [IW-1:0]       st_raddr;
  logic signed [C-1:0] st_rd [3];
  logic [2:0]          ord_we;
  logic [IW-1:0]       ord_raddr;
  logic [IW-1:0]       ord_rd [3];
  logic [IW-1:0]       ord_sel;

  // candidate row
  knp_pkg::chain_cmd_t ch_cmd;
  logic                ch_hit;
  logic [DW-1:0]       ch_thr, ch_rd_d;
  logic [IW-1:0]       ch_rd_p;
  logic [KW-1:0]       ch_sel;

  // search helpers
  logic [NW:0]   lohi_sum;
  logic [NW-1:0] mid;
  logic [NW-1:0] pos_s;
  logic [NW:0]   hsum;
  logic          prb_ok;
  logic [NW:0]   prb_rank;
  logic          ins_ok;
  logic          out_load;

  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign st_we    = in_fire && (f_action == knp_pkg::ACT_LOAD_POINT)
                    && (int'(f_pidx) < MAX_POINTS);

  for (genvar a = 0; a < 3; a++) begin : g_mem
    knp_ram #(.WIDTH(C), .DEPTH(MAX_POINTS)) u_store (
      .clk   (clk),
      .we    (st_we),
      .waddr (IW'(f_pidx)),
      .wdata (f_coord[a]),
      .raddr (st_raddr),
      .rdata (st_rd[a])
    );
    assign ord_we[a] = in_fire && (f_action == knp_pkg::ACT_LOAD_ORDER)
                       && (f_axis == 2'(a)) && (int'(f_rank) < MAX_POINTS)
                       && (int'(f_pidx) < MAX_POINTS);
    knp_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_order (
      .clk   (clk),
      .we    (ord_we[a]),
      .waddr (IW'(f_rank)),
      .wdata (IW'(f_pidx)),
      .raddr (ord_raddr),
      .rdata (ord_rd[a])
    );
  end

  assign ord_sel   = ord_rd[ax_r];
  assign lohi_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = lohi_sum[NW:1];
  assign pos_s     = pos_r[slot_r[2:1]];
  assign hsum      = {1'b0, pos_s} + {1'b0, ring_r};
  assign prb_ok    = slot_r[0] ? (hsum <= {1'b0, n_r}) : (ring_r <= pos_s);
  assign prb_rank  = slot_r[0] ? (hsum - (NW + 1)'(1)) : {1'b0, pos_s - ring_r};
  assign ord_raddr = (state_r == S_LOC_ORD) ? IW'(mid - NW'(1)) : IW'(prb_rank);
  assign st_raddr  = (state_r == S_SEED_RD) ? IW'(cnt_r) : ord_sel;
  assign ins_ok    = seeding_r || ((d_r < thr_r) && !ch_hit);
  assign ch_sel    = (state_r == S_EMIT) ? cnt_r : cp_r;
  assign out_load  = !out_tvalid_r || out_tready;

  assign ch_cmd.clear  = in_fire && (f_action == knp_pkg::ACT_QUERY);
  assign ch_cmd.insert = (state_r == S_ACT) && ins_ok;
  assign ch_cmd.trunc  = (state_r == S_BOUND);

  knp_cand_chain #(.DW(DW), .IW(IW), .KW(KW), .CAND(CAND)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ch_cmd),
    .new_d   (d_r),
    .new_p   (p_r),
    .kk      (kk_r),
    .sel     (ch_sel),
    .hit_any (ch_hit),
    .thr     (ch_thr),
    .rd_d    (ch_rd_d),
    .rd_p    (ch_rd_p)
  );

  always_comb begin
    int n_i;
    int k_i;
    n_i = (int'(pc_r) > MAX_POINTS) ? MAX_POINTS : int'(pc_r);
    k_i = (int'(nc_r) > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(nc_r);
    if (k_i > n_i) begin
      k_i = n_i;
    end
    n_calc  = NW'(n_i);
    kk_calc = KW'(k_i);
  end

  always_comb begin
    logic [NW-1:0]       lo_new, hi_new;
    logic signed [C:0]   dx;
    logic [C-1:0]        mag;
    logic [DW-1:0]       m0, m1, m2;
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    out_idx_nxt    = out_idx_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    ax_nxt         = ax_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    pos_nxt        = pos_r;
    q_nxt          = q_r;
    n_nxt          = n_r;
    kk_nxt         = kk_r;
    cnt_nxt        = cnt_r;
    cp_nxt         = cp_r;
    ring_nxt       = ring_r;
    slot_nxt       = slot_r;
    seeding_nxt    = seeding_r;
    p_nxt          = p_r;
    sq_nxt         = sq_r;
    d_nxt          = d_r;
    off_nxt        = off_r;
    offs_nxt       = offs_r;
    thr_nxt        = thr_r;
    bound_nxt      = bound_r;
    lo_new         = lo_r;
    hi_new         = hi_r;
    dx             = '0;
    mag            = '0;
    m0             = '0;
    m1             = '0;
    m2             = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (f_action == knp_pkg::ACT_QUERY) && (kk_calc != '0)) begin
          q_nxt     = f_coord;
          n_nxt     = n_calc;
          kk_nxt    = kk_calc;
          ax_nxt    = knp_pkg::AXIS_X;
          lo_nxt    = '0;
          hi_nxt    = n_calc + NW'(1);
          state_nxt = S_LOC_ORD;
        end
      end
      S_LOC_ORD: state_nxt = S_LOC_PT;
      S_LOC_PT:  state_nxt = S_LOC_CMP;
      S_LOC_CMP: begin
        if (q_r[ax_r] >= st_rd[ax_r]) begin
          lo_new = mid;
        end else begin
          hi_new = mid;
        end
        lo_nxt = lo_new;
        hi_nxt = hi_new;
        if ((hi_new - lo_new) == NW'(1)) begin
          pos_nxt[ax_r] = lo_new;
          if (ax_r == knp_pkg::AXIS_Z) begin
            cnt_nxt     = '0;
            seeding_nxt = 1'b1;
            state_nxt   = S_SEED_RD;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            lo_nxt    = '0;
            hi_nxt    = n_r + NW'(1);
            state_nxt = S_LOC_ORD;
          end
        end else begin
          state_nxt = S_LOC_ORD;
        end
      end
      S_SEED_RD: begin
        p_nxt     = IW'(cnt_r);
        state_nxt = S_SQ;
      end
      S_SQ: begin
        for (int a = 0; a < 3; a++) begin
          dx = {st_rd[a][C-1], st_rd[a]} - {q_r[a][C-1], q_r[a]};
          mag = dx[C] ? C'(-dx) : C'(dx);
          sq_nxt[a] = SW'(mag) * SW'(mag);
        end
        state_nxt = S_SUM;
      end
      S_SUM: begin
        d_nxt     = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
        off_nxt   = sq_r[ax_r];
        state_nxt = S_ACT;
      end
      S_ACT: begin
        if (seeding_r) begin
          if ((cnt_r + KW'(1)) == kk_r) begin
            seeding_nxt = 1'b0;
            ring_nxt    = NW'(1);
            cp_nxt      = '0;
            state_nxt   = S_RING;
          end else begin
            cnt_nxt   = cnt_r + KW'(1);
            state_nxt = S_SEED_RD;
          end
        end else begin
          offs_nxt[slot_r] = DW'(off_r);
          if (slot_r == 3'd5) begin
            state_nxt = S_BOUND;
          end else begin
            slot_nxt  = slot_r + 3'd1;
            state_nxt = S_PRB_SEL;
          end
        end
      end
      S_RING: begin
        thr_nxt   = ch_thr;
        slot_nxt  = '0;
        state_nxt = S_PRB_SEL;
      end
      S_PRB_SEL: begin
        ax_nxt = slot_r[2:1];
        if (prb_ok) begin
          state_nxt = S_PRB_PT;
        end else begin
          offs_nxt[slot_r] = thr_r;
          if (slot_r == 3'd5) begin
            state_nxt = S_BOUND;
          end else begin
            slot_nxt = slot_r + 3'd1;
          end
        end
      end
      S_PRB_PT: begin
        p_nxt     = ord_sel;
        state_nxt = S_SQ;
      end
      S_BOUND: begin
        m0 = (offs_r[0] < offs_r[1]) ? offs_r[0] : offs_r[1];
        m1 = (offs_r[2] < offs_r[3]) ? offs_r[2] : offs_r[3];
        m2 = (offs_r[4] < offs_r[5]) ? offs_r[4] : offs_r[5];
        bound_nxt = BW'(m0) + BW'(m1) + BW'(m2);
        state_nxt = S_CONF;
      end
      S_CONF: begin
        if (BW'(ch_rd_d) <= bound_r) begin
          if ((cp_r + KW'(1)) == kk_r) begin
            cnt_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            cp_nxt = cp_r + KW'(1);
          end
        end else begin
          ring_nxt  = ring_r + NW'(1);
          state_nxt = S_RING;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_idx_nxt    = knp_pkg::NIDX_W'(ch_rd_p);
          out_pos_nxt    = knp_pkg::NPOS_W'(cnt_r);
          out_last_nxt   = ((cnt_r + KW'(1)) == kk_r);
          if ((cnt_r + KW'(1)) == kk_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + KW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      pc_r         <= knp_pkg::PCOUNT_W'(1);
      nc_r         <= knp_pkg::NCOUNT_W'(1);
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_idx_r    <= out_idx_nxt;
      out_pos_r    <= out_pos_nxt;
      out_last_r   <= out_last_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          knp_pkg::REG_POINT_COUNT:    pc_r <= cfg_data[knp_pkg::PCOUNT_W-1:0];
          knp_pkg::REG_NEIGHBOR_COUNT: nc_r <= cfg_data[knp_pkg::NCOUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ax_r      <= ax_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    pos_r     <= pos_nxt;
    q_r       <= q_nxt;
    n_r       <= n_nxt;
    kk_r      <= kk_nxt;
    cnt_r     <= cnt_nxt;
    cp_r      <= cp_nxt;
    ring_r    <= ring_nxt;
    slot_r    <= slot_nxt;
    seeding_r <= seeding_nxt;
    p_r       <= p_nxt;
    sq_r      <= sq_nxt;
    d_r       <= d_nxt;
    off_r     <= off_nxt;
    offs_r    <= offs_nxt;
    thr_r     <= thr_nxt;
    bound_r   <= bound_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_pos_r, out_idx_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_conf_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONF) |-> (cp_r < kk_r))
    else $error("confirm index reached neighbor count");

  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (f_action == knp_pkg::ACT_QUERY) && (kk_calc == '0)) |=>
    (state_r == S_IDLE))
    else $error("query with no neighbors left idle");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("item after last neighbor");
`endif

endmodule
